// ===== hw/rtl/bnhs_pkg.sv =====
`default_nettype none

package bnhs_pkg;

	localparam int unsigned GRID_SIDE_MAX_DEF = 32;
	localparam int unsigned GRID_SIDE_HIGH    = 256;

	localparam int unsigned SIDE_W     = 16;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned IDX_MAX_W  = $clog2(GRID_SIDE_HIGH * GRID_SIDE_HIGH);
	localparam int unsigned GRID_MAX_W = $clog2(GRID_SIDE_HIGH + 1);

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIDE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIDE   = 1'd1;

	localparam logic [SIDE_W-1:0] MATRIX_SIDE_RST = 16'd1024;
	localparam logic [SIDE_W-1:0] TILE_SIDE_RST   = 16'd32;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_GRID_EMPTY = 2'd1,
		ST_GRID_OVER  = 2'd2
	} status_t;

	// one classified element, as handed from the front to the back
	typedef struct packed {
		logic                  hit;
		logic                  last;
		status_t               status;
		logic [IDX_MAX_W-1:0]  idx;
		logic [GRID_MAX_W-1:0] grid;
	} upd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_WRITE,
		B_SCAN,
		B_DRAIN,
		B_MEAN
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bnhs_in_if.sv =====
`default_nettype none

interface bnhs_in_if import bnhs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIDE_W-1:0] row_index;
	logic [SIDE_W-1:0] column_index;
	logic              is_nonzero;
	logic              final_element;

	modport source (
		output valid, row_index, column_index, is_nonzero, final_element,
		input  ready
	);
	modport sink (
		input  valid, row_index, column_index, is_nonzero, final_element,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/bnhs_out_if.sv =====
`default_nettype none

interface bnhs_out_if import bnhs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] largest_count;
	logic [COUNT_W-1:0] smallest_count;
	logic [COUNT_W-1:0] mean_count;
	logic [COUNT_W-1:0] count_spread;
	logic [1:0]         status;

	modport source (
		output valid, largest_count, smallest_count, mean_count, count_spread, status,
		input  ready
	);
	modport sink (
		input  valid, largest_count, smallest_count, mean_count, count_spread, status,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/bnhs_front.sv =====
`default_nettype none

module bnhs_front import bnhs_pkg::*; #(
	parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bnhs_in_if.sink              element,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data,
	input  logic                 hold,
	output upd_t                 upd,
	output logic                 upd_valid,
	input  logic                 upd_ready
);

	localparam int unsigned ROW_W  = (GRID_SIDE_MAX > 1) ? $clog2(GRID_SIDE_MAX) : 1;
	localparam int unsigned STEP_W = $clog2(SIDE_W);
	localparam int unsigned LANES  = 3;

	front_state_t state_q, state_n;

	logic [SIDE_W-1:0] matrix_side_q, tile_side_q;
	logic [SIDE_W-1:0] row_q, col_q, msd_q, tsd_q;
	logic              nz_q, last_q;
	logic [STEP_W-1:0] step_q;

	// lane 0: matrix side, lane 1: row, lane 2: column; all divided by the tile side
	logic [SIDE_W-1:0] rem_q [LANES];
	logic [SIDE_W-1:0] dvd_q [LANES];
	logic [SIDE_W-1:0] rem_n [LANES];
	logic [SIDE_W-1:0] dvd_n [LANES];
	logic [SIDE_W:0]   trial [LANES];
	logic [SIDE_W:0]   diff  [LANES];

	logic [SIDE_W-1:0]    grid_full, br, bc;
	status_t              status;
	logic                 hit;
	logic [IDX_MAX_W-1:0] idx_calc;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {rem_q[l], dvd_q[l][SIDE_W-1]};
			diff[l]  = trial[l] - {1'b0, tsd_q};
			if (trial[l] >= {1'b0, tsd_q}) begin
				rem_n[l] = diff[l][SIDE_W-1:0];
				dvd_n[l] = {dvd_q[l][SIDE_W-2:0], 1'b1};
			end else begin
				rem_n[l] = trial[l][SIDE_W-1:0];
				dvd_n[l] = {dvd_q[l][SIDE_W-2:0], 1'b0};
			end
		end
	end

	// classify once the quotients are in
	always_comb begin
		grid_full = dvd_q[0];
		br        = dvd_q[1];
		bc        = dvd_q[2];
		if (tsd_q == '0 || grid_full == '0) begin
			status = ST_GRID_EMPTY;
		end else if (grid_full > SIDE_W'(GRID_SIDE_MAX)) begin
			status = ST_GRID_OVER;
		end else begin
			status = ST_OK;
		end
		hit = nz_q && (status == ST_OK) && (row_q < msd_q) && (col_q < msd_q)
			&& (br < grid_full) && (bc < grid_full);
		idx_calc = IDX_MAX_W'(br[ROW_W-1:0]) * IDX_MAX_W'(GRID_SIDE_MAX)
			+ IDX_MAX_W'(bc[ROW_W-1:0]);
	end

	always_comb begin
		state_n       = state_q;
		element.ready = 1'b0;
		upd_valid     = 1'b0;
		upd.hit       = hit;
		upd.last      = last_q;
		upd.status    = status;
		upd.idx       = idx_calc;
		upd.grid      = grid_full[GRID_MAX_W-1:0];
		case (state_q)
			F_IDLE: begin
				element.ready = !hold;
				if (element.valid && !hold) begin
					state_n = F_DIV;
				end
			end
			F_DIV: begin
				if (step_q == STEP_W'(SIDE_W - 1)) begin
					state_n = F_PUSH;
				end
			end
			F_PUSH: begin
				upd_valid = 1'b1;
				if (upd_ready) begin
					state_n = F_IDLE;
				end
			end
			default: state_n = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			step_q        <= '0;
			matrix_side_q <= MATRIX_SIDE_RST;
			tile_side_q   <= TILE_SIDE_RST;
		end else begin
			state_q <= state_n;
			if (state_q == F_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MATRIX_SIDE: matrix_side_q <= cfg_data;
					REG_TILE_SIDE:   tile_side_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && element.valid && !hold) begin
			row_q    <= element.row_index;
			col_q    <= element.column_index;
			nz_q     <= element.is_nonzero;
			last_q   <= element.final_element;
			msd_q    <= matrix_side_q;
			tsd_q    <= tile_side_q;
			dvd_q[0] <= matrix_side_q;
			dvd_q[1] <= element.row_index;
			dvd_q[2] <= element.column_index;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (state_q == F_DIV) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= rem_n[l];
				dvd_q[l] <= dvd_n[l];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bnhs_queue.sv =====
`default_nettype none

module bnhs_queue import bnhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  upd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output upd_t pop_data
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	upd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bnhs_back.sv =====
`default_nettype none

module bnhs_back import bnhs_pkg::*; #(
	parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_ready,
	input  upd_t     q_data,
	output logic     clearing,
	bnhs_out_if.source summary
);

	localparam int unsigned DEPTH     = GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned ROW_W     = (GRID_SIDE_MAX > 1) ? $clog2(GRID_SIDE_MAX) : 1;
	localparam int unsigned SUM_W     = COUNT_W + IDX_W;
	localparam int unsigned GSQ_W     = $clog2(DEPTH + 1);
	localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

	back_state_t state_q, state_n;

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [COUNT_W-1:0] mem_wdata, inc;

	upd_t               ent_q;
	logic [IDX_W-1:0]   addr_q;
	logic [ROW_W-1:0]   r_q, c_q;
	logic               valid_s1, tag_s1, in_grid;
	logic [COUNT_W-1:0] hi_q, lo_q;
	logic [SUM_W-1:0]   sum_q, sum_n;
	logic [GSQ_W-1:0]   gsq_q, div_rem_q, div_rem_n;
	logic [GSQ_W:0]     trial, diff;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [2*GRID_MAX_W-1:0] grid_sq;

	logic pop, start_scan, last_addr, last_col, last_step, result_load, ok;

	logic               out_valid_q;
	logic [COUNT_W-1:0] largest_q, smallest_q, mean_q, spread_q;
	logic [1:0]         status_q;

	assign clearing  = (state_q == B_CLEAR);
	assign inc       = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
	assign last_addr = (addr_q == IDX_W'(DEPTH - 1));
	assign last_col  = (c_q == ROW_W'(GRID_SIDE_MAX - 1));
	assign last_step = (div_cnt_q == DIV_CNT_W'(SUM_W - 1));
	assign in_grid   = (GRID_MAX_W'(r_q) < ent_q.grid) && (GRID_MAX_W'(c_q) < ent_q.grid);
	assign ok        = (ent_q.status == ST_OK);
	assign grid_sq   = {{GRID_MAX_W{1'b0}}, ent_q.grid} * {{GRID_MAX_W{1'b0}}, ent_q.grid};

	// one restoring step of the mean division, worked in place on the sum
	assign trial     = {div_rem_q, sum_q[SUM_W-1]};
	assign diff      = trial - {1'b0, gsq_q};
	assign div_rem_n = (trial >= {1'b0, gsq_q}) ? diff[GSQ_W-1:0] : trial[GSQ_W-1:0];
	assign sum_n     = {sum_q[SUM_W-2:0], trial >= {1'b0, gsq_q}};

	assign summary.valid          = out_valid_q;
	assign summary.largest_count  = largest_q;
	assign summary.smallest_count = smallest_q;
	assign summary.mean_count     = mean_q;
	assign summary.count_spread   = spread_q;
	assign summary.status         = status_q;

	always_comb begin
		state_n     = state_q;
		pop         = 1'b0;
		start_scan  = 1'b0;
		result_load = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = addr_q;
		mem_wdata   = '0;
		mem_raddr   = addr_q;
		case (state_q)
			B_CLEAR: begin
				mem_we = 1'b1;
				if (last_addr) begin
					state_n = B_IDLE;
				end
			end
			B_IDLE: begin
				mem_raddr = q_data.idx[IDX_W-1:0];
				// hold a final element back until the previous result has gone
				pop = q_valid && !(q_data.last && out_valid_q);
				if (pop) begin
					if (q_data.hit) begin
						state_n = B_WRITE;
					end else if (q_data.last) begin
						start_scan = 1'b1;
						state_n    = B_SCAN;
					end
				end
			end
			B_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = ent_q.idx[IDX_W-1:0];
				mem_wdata = inc;
				if (ent_q.last) begin
					start_scan = 1'b1;
					state_n    = B_SCAN;
				end else begin
					state_n = B_IDLE;
				end
			end
			B_SCAN: begin
				// read each counter and zero it in the same pass
				mem_we = 1'b1;
				if (last_addr) begin
					state_n = B_DRAIN;
				end
			end
			B_DRAIN: begin
				state_n = B_MEAN;
			end
			B_MEAN: begin
				if (last_step) begin
					result_load = 1'b1;
					state_n     = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	assign q_ready = pop;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			addr_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			div_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			valid_s1 <= (state_q == B_SCAN);
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (summary.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					addr_q <= last_addr ? '0 : addr_q + 1'b1;
				end
				B_SCAN: begin
					if (last_addr) begin
						addr_q <= '0;
						r_q    <= '0;
						c_q    <= '0;
					end else begin
						addr_q <= addr_q + 1'b1;
						if (last_col) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				B_MEAN: begin
					div_cnt_q <= last_step ? '0 : div_cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_data;
		end
		tag_s1 <= ok && in_grid;
		if (start_scan) begin
			hi_q  <= '0;
			lo_q  <= '1;
			sum_q <= '0;
		end else if (valid_s1 && tag_s1) begin
			if (rd_data_q > hi_q) begin
				hi_q <= rd_data_q;
			end
			if (rd_data_q < lo_q) begin
				lo_q <= rd_data_q;
			end
			sum_q <= sum_q + SUM_W'(rd_data_q);
		end else if (state_q == B_MEAN) begin
			sum_q <= sum_n;
		end
		if (state_q == B_DRAIN) begin
			gsq_q     <= grid_sq[GSQ_W-1:0];
			div_rem_q <= '0;
		end else if (state_q == B_MEAN) begin
			div_rem_q <= div_rem_n;
		end
		if (result_load) begin
			largest_q  <= ok ? hi_q : '0;
			smallest_q <= ok ? lo_q : '0;
			mean_q     <= ok ? sum_n[COUNT_W-1:0] : '0;
			spread_q   <= ok ? hi_q - lo_q : '0;
			status_q   <= ent_q.status;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/block_nonzero_histogram_spread_unit.sv =====
`default_nettype none

// Channel  Dir  Payload                                                    Transfer
// element  in   row_index, column_index, is_nonzero, final_element        valid & ready
// summary  out  largest_count, smallest_count, mean_count, count_spread,   valid & ready
//               status
// cfg      in   cfg_index, cfg_data                                         cfg_we
//
// The front takes one element at a time and takes no new one until the last has gone to
// the queue: three 16-step restoring dividers find the tile row, tile column and grid side.
// The back updates a counter by a read and then a write back, fed by a two-entry queue.
// A final element starts a scan of every counter, which also zeroes the store, then a drain
// state, then the restoring mean division.
// After reset a clearing pass over every counter runs before the first element is taken.
// A waiting result holds the next final element in the queue; other elements flow on.

module block_nonzero_histogram_spread_unit import bnhs_pkg::*; #(
	parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bnhs_in_if.sink              element,
	bnhs_out_if.source           summary,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data
);

	upd_t front_upd, queue_upd;
	logic front_valid, front_ready;
	logic queue_valid, queue_ready;
	logic clearing;

	bnhs_front #(
		.GRID_SIDE_MAX(GRID_SIDE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.element   (element),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hold      (clearing),
		.upd       (front_upd),
		.upd_valid (front_valid),
		.upd_ready (front_ready)
	);

	bnhs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_upd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_upd)
	);

	bnhs_back #(
		.GRID_SIDE_MAX(GRID_SIDE_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (queue_valid),
		.q_ready  (queue_ready),
		.q_data   (queue_upd),
		.clearing (clearing),
		.summary  (summary)
	);

endmodule

`default_nettype wire
